>>> hdl/bfa_pkg.sv
// Shared types, constants and mask helpers for the bitmap frame allocator.
package bfa_pkg;

  // Map geometry: one bit per frame, 32 frames per memory word.
  localparam int NUM_FRAMES = 1024;
  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = NUM_FRAMES / WORD_W;
  localparam int WA_W       = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int FR_W       = 10;
  localparam int CNT_W      = 11;
  localparam int RUN_LW     = BIT_W + 1;

  // Request codes.
  localparam logic [2:0] OP_INIT      = 3'd0;
  localparam logic [2:0] OP_ALLOC_ONE = 3'd1;
  localparam logic [2:0] OP_ALLOC_RUN = 3'd2;
  localparam logic [2:0] OP_CLAIM_RUN = 3'd3;
  localparam logic [2:0] OP_FREE_ONE  = 3'd4;
  localparam logic [2:0] OP_FREE_RUN  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_COUNT    = 2'd0;
  localparam logic [1:0] REG_RESERVED_COUNT = 2'd1;
  localparam logic [1:0] REG_SEARCH_START   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_FILL,
    S_DONE
  } eng_state_t;

  // One access to the map memory.
  typedef struct packed {
    logic              rd_en;
    logic [WA_W-1:0]   rd_addr;
    logic              wr_en;
    logic [WA_W-1:0]   wr_addr;
    logic [WORD_W-1:0] wmask;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  // Answer to one request.
  typedef struct packed {
    logic [1:0]      status;
    logic [FR_W-1:0] frame;
  } result_t;

  // Bits of word w whose frame number is at least r.
  function automatic logic [WORD_W-1:0] ge_mask(logic [WA_W-1:0] w, logic [CNT_W-1:0] r);
    logic [WORD_W-1:0] m;
    logic [BIT_W-1:0]  bb;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      bb = BIT_W'(b);
      m[b] = {1'b0, w, bb} >= r;
    end
    return m;
  endfunction

  // Bits of word w whose frame number lies in [lo, hi].
  function automatic logic [WORD_W-1:0] span_mask(logic [WA_W-1:0] w, logic [FR_W-1:0] lo,
                                                 logic [FR_W-1:0] hi);
    logic [WORD_W-1:0] m;
    logic [BIT_W-1:0]  bb;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      bb = BIT_W'(b);
      m[b] = ({w, bb} >= lo) && ({w, bb} <= hi);
    end
    return m;
  endfunction

endpackage

>>> hdl/bfa_map_mem.sv
// Free-bit map storage: one word per row, bit write mask, registered read.
module bfa_map_mem (
  input  logic                               clk,
  input  bfa_pkg::mem_req_t                  req,
  output logic [bfa_pkg::WORD_W-1:0]         rdata
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] mem_r [NUM_WORDS];
  logic [WORD_W-1:0] rdata_r;

  // Masked write of the selected bits.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (req.wmask[b]) begin
          mem_r[req.wr_addr][b] <= req.wdata[b];
        end
      end
    end
  end

  // Registered read; rdata keeps its value while rd_en is low.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem_r[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/bfa_engine.sv
// Request sequencer: word scans, run tracking and masked fills of the map.
module bfa_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [2:0]                    opcode,
  input  logic [bfa_pkg::FR_W-1:0]      frame_index,
  input  logic [bfa_pkg::CNT_W-1:0]     page_count,
  input  logic [bfa_pkg::CNT_W-1:0]     frame_count,
  input  logic [bfa_pkg::CNT_W-1:0]     reserved_count,
  input  logic [bfa_pkg::FR_W-1:0]      search_start,
  output logic                          idle,
  output logic                          res_valid,
  output bfa_pkg::result_t              res,
  input  logic                          res_take,
  output bfa_pkg::mem_req_t             mem_req,
  input  logic [bfa_pkg::WORD_W-1:0]    rdata
);
  import bfa_pkg::*;

  eng_state_t          state_r, state_nxt;
  logic                quiet_r, quiet_nxt;
  logic                run_mode_r, run_mode_nxt;
  logic                pass_b_r, pass_b_nxt;
  logic [FR_W-1:0]     s_r, s_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    run_r, run_nxt;
  logic [WA_W-1:0]     iss_w_r, iss_w_nxt;
  logic [WA_W-1:0]     end_w_r, end_w_nxt;
  logic [WA_W-1:0]     ev_w_r, ev_w_nxt;
  logic                pend_r, pend_nxt;
  logic                issuing_r, issuing_nxt;
  logic [FR_W-1:0]     lo_f_r, lo_f_nxt;
  logic [CNT_W-1:0]    hi_ex_r, hi_ex_nxt;
  logic [FR_W-1:0]     fill_lo_r, fill_lo_nxt;
  logic [FR_W-1:0]     fill_hi_r, fill_hi_nxt;
  logic                fill_val_r, fill_val_nxt;
  logic [WA_W-1:0]     fill_w_r, fill_w_nxt;
  logic [CNT_W-1:0]    init_r_r, init_r_nxt;
  result_t             res_r, res_nxt;

  // Word evaluation signals.
  logic [WORD_W-1:0]   cand;
  logic [WORD_W-1:0]   d;
  logic                pf [RUN_LW][WORD_W];
  logic [RUN_LW-1:0]   pl [RUN_LW][WORD_W];
  logic [WORD_W-1:0]   run_hit;
  logic [CNT_W:0]      tot;
  logic [WORD_W-1:0]   hitv;
  logic                hit;
  logic [BIT_W-1:0]    hit_b;
  logic [FR_W-1:0]     hit_f;
  logic [CNT_W:0]      run_start;

  // Request decode signals.
  logic [CNT_W-1:0]    nf;
  logic [CNT_W:0]      range_end;
  logic [FR_W-1:0]     s_eff;
  logic [CNT_W-1:0]    nf_m1;
  logic [FR_W-1:0]     s_m1;

  assign nf        = (frame_count > CNT_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : frame_count;
  assign nf_m1     = nf - CNT_W'(1);
  assign range_end = {2'b00, frame_index} + {1'b0, page_count};
  assign s_eff     = ({1'b0, search_start} < nf) ? search_start : '0;
  assign s_m1      = s_r - FR_W'(1);

  // Candidate bits of the word in evaluation: inside the pass bounds.
  always_comb begin
    logic [BIT_W-1:0] bb;
    cand = '0;
    for (int b = 0; b < WORD_W; b++) begin
      bb = BIT_W'(b);
      cand[b] = ({ev_w_r, bb} >= lo_f_r) && ({1'b0, ev_w_r, bb} < hi_ex_r);
    end
  end
  assign d = rdata & cand;

  // Prefix of free runs ending at each bit: all-free flag and run length.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      pf[0][b] = d[b];
      pl[0][b] = RUN_LW'(d[b]);
    end
    for (int k = 1; k < RUN_LW; k++) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (b >= (1 << (k - 1)) && pf[k-1][b]) begin
          pf[k][b] = pf[k-1][b - (1 << (k - 1))];
          pl[k][b] = pl[k-1][b] + pl[k-1][b - (1 << (k - 1))];
        end else begin
          pf[k][b] = pf[k-1][b];
          pl[k][b] = pl[k-1][b];
        end
      end
    end
  end

  // A run reaches the requested length at bit b.
  always_comb begin
    run_hit = '0;
    tot = '0;
    for (int b = 0; b < WORD_W; b++) begin
      tot = pf[RUN_LW-1][b] ? ({1'b0, run_r} + (CNT_W+1)'(pl[RUN_LW-1][b]))
                            : (CNT_W+1)'(pl[RUN_LW-1][b]);
      run_hit[b] = tot >= {1'b0, cnt_r};
    end
  end

  assign hitv = run_mode_r ? run_hit : d;
  assign hit  = |hitv;

  // Lowest hit position.
  always_comb begin
    hit_b = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (hitv[b]) begin
        hit_b = BIT_W'(b);
      end
    end
  end
  assign hit_f     = {ev_w_r, hit_b};
  assign run_start = {2'b00, hit_f} + (CNT_W+1)'(1) - {1'b0, cnt_r};

  // Register bank.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      quiet_r   <= 1'b1;
      fill_w_r  <= '0;
      init_r_r  <= '0;
      pend_r    <= 1'b0;
      issuing_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      quiet_r   <= quiet_nxt;
      fill_w_r  <= fill_w_nxt;
      init_r_r  <= init_r_nxt;
      pend_r    <= pend_nxt;
      issuing_r <= issuing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_mode_r <= run_mode_nxt;
    pass_b_r   <= pass_b_nxt;
    s_r        <= s_nxt;
    cnt_r      <= cnt_nxt;
    run_r      <= run_nxt;
    iss_w_r    <= iss_w_nxt;
    end_w_r    <= end_w_nxt;
    ev_w_r     <= ev_w_nxt;
    lo_f_r     <= lo_f_nxt;
    hi_ex_r    <= hi_ex_nxt;
    fill_lo_r  <= fill_lo_nxt;
    fill_hi_r  <= fill_hi_nxt;
    fill_val_r <= fill_val_nxt;
    res_r      <= res_nxt;
  end

  // Next state and memory accesses.
  always_comb begin
    state_nxt    = state_r;
    quiet_nxt    = quiet_r;
    run_mode_nxt = run_mode_r;
    pass_b_nxt   = pass_b_r;
    s_nxt        = s_r;
    cnt_nxt      = cnt_r;
    run_nxt      = run_r;
    iss_w_nxt    = iss_w_r;
    end_w_nxt    = end_w_r;
    ev_w_nxt     = ev_w_r;
    pend_nxt     = 1'b0;
    issuing_nxt  = issuing_r;
    lo_f_nxt     = lo_f_r;
    hi_ex_nxt    = hi_ex_r;
    fill_lo_nxt  = fill_lo_r;
    fill_hi_nxt  = fill_hi_r;
    fill_val_nxt = fill_val_r;
    fill_w_nxt   = fill_w_r;
    init_r_nxt   = init_r_r;
    res_nxt      = res_r;
    mem_req      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt = '{status: ST_BAD, frame: '0};
          state_nxt = S_DONE;
          unique case (opcode)
            OP_INIT: begin
              init_r_nxt = (reserved_count < nf) ? reserved_count : nf;
              fill_w_nxt = '0;
              res_nxt.status = ST_OK;
              state_nxt = S_INIT;
            end
            OP_ALLOC_ONE: begin
              if (nf == '0) begin
                res_nxt.status = ST_NOSPACE;
              end else begin
                run_mode_nxt = 1'b0;
                pass_b_nxt   = 1'b0;
                s_nxt        = s_eff;
                iss_w_nxt    = s_eff[FR_W-1 -: WA_W];
                end_w_nxt    = nf_m1[FR_W-1 -: WA_W];
                lo_f_nxt     = s_eff;
                hi_ex_nxt    = nf;
                issuing_nxt  = 1'b1;
                state_nxt    = S_SCAN;
              end
            end
            OP_ALLOC_RUN: begin
              if (page_count != '0 && page_count <= nf) begin
                run_mode_nxt = 1'b1;
                cnt_nxt      = page_count;
                run_nxt      = '0;
                iss_w_nxt    = '0;
                end_w_nxt    = nf_m1[FR_W-1 -: WA_W];
                lo_f_nxt     = '0;
                hi_ex_nxt    = nf;
                issuing_nxt  = 1'b1;
                state_nxt    = S_SCAN;
              end
            end
            OP_CLAIM_RUN, OP_FREE_RUN: begin
              if (frame_index != '0 && page_count != '0 && range_end <= {1'b0, nf}) begin
                fill_lo_nxt  = frame_index;
                fill_hi_nxt  = FR_W'(range_end - (CNT_W+1)'(1));
                fill_val_nxt = (opcode == OP_FREE_RUN);
                fill_w_nxt   = frame_index[FR_W-1 -: WA_W];
                res_nxt      = '{status: ST_OK, frame: frame_index};
                state_nxt    = S_FILL;
              end
            end
            OP_FREE_ONE: begin
              if (frame_index != '0 && ({1'b0, frame_index} + CNT_W'(1)) <= nf) begin
                fill_lo_nxt  = frame_index;
                fill_hi_nxt  = frame_index;
                fill_val_nxt = 1'b1;
                fill_w_nxt   = frame_index[FR_W-1 -: WA_W];
                res_nxt      = '{status: ST_OK, frame: frame_index};
                state_nxt    = S_FILL;
              end
            end
            default: begin
              res_nxt.status = ST_BAD;
            end
          endcase
        end
      end

      // Whole-map sweep: frames below the reserved count become used.
      S_INIT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = fill_w_r;
        mem_req.wmask   = '1;
        mem_req.wdata   = ge_mask(fill_w_r, init_r_r);
        fill_w_nxt      = fill_w_r + WA_W'(1);
        if (fill_w_r == WA_W'(NUM_WORDS - 1)) begin
          quiet_nxt = 1'b0;
          state_nxt = quiet_r ? S_IDLE : S_DONE;
        end
      end

      // One word read per cycle; the word read last cycle is evaluated now.
      S_SCAN: begin
        if (pend_r && hit) begin
          issuing_nxt = 1'b0;
          fill_val_nxt = 1'b0;
          state_nxt = S_FILL;
          if (run_mode_r) begin
            fill_lo_nxt = run_start[FR_W-1:0];
            fill_w_nxt  = run_start[FR_W-1 -: WA_W];
            res_nxt     = '{status: ST_OK, frame: run_start[FR_W-1:0]};
          end else begin
            fill_lo_nxt = hit_f;
            fill_w_nxt  = ev_w_r;
            res_nxt     = '{status: ST_OK, frame: hit_f};
          end
          fill_hi_nxt = hit_f;
        end else if (pend_r && ev_w_r == end_w_r) begin
          if (!run_mode_r && !pass_b_r && s_r != '0) begin
            // Wrap: search frames below the start point.
            pass_b_nxt  = 1'b1;
            iss_w_nxt   = '0;
            end_w_nxt   = s_m1[FR_W-1 -: WA_W];
            lo_f_nxt    = '0;
            hi_ex_nxt   = {1'b0, s_r};
            issuing_nxt = 1'b1;
          end else begin
            issuing_nxt = 1'b0;
            res_nxt = '{status: ST_NOSPACE, frame: '0};
            state_nxt = S_DONE;
          end
        end else begin
          if (pend_r) begin
            run_nxt = pf[RUN_LW-1][WORD_W-1]
                    ? run_r + CNT_W'(WORD_W)
                    : CNT_W'(pl[RUN_LW-1][WORD_W-1]);
          end
          if (issuing_r) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = iss_w_r;
            pend_nxt        = 1'b1;
            ev_w_nxt        = iss_w_r;
            if (iss_w_r == end_w_r) begin
              issuing_nxt = 1'b0;
            end else begin
              iss_w_nxt = iss_w_r + WA_W'(1);
            end
          end
        end
      end

      // Masked write of a frame span, one word per cycle.
      S_FILL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = fill_w_r;
        mem_req.wmask   = span_mask(fill_w_r, fill_lo_r, fill_hi_r);
        mem_req.wdata   = fill_val_r ? '1 : '0;
        fill_w_nxt      = fill_w_r + WA_W'(1);
        if (fill_w_r == fill_hi_r[FR_W-1 -: WA_W]) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

>>> hdl/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: ports, configuration and result register.
//
//  Channel   Ports                               Payload
//  in        in_tvalid/in_tready/in_tdata        opcode, frame_index, page_count
//  out       out_tvalid/out_tready/out_tdata     status, frame_result
//  cfg       cfg_wr_en/cfg_index/cfg_wdata       frame_count, reserved_count, search_start
//
// Single-frame and run allocation scan the map one 32-frame memory word per cycle
// and then write the words of the found frames; the single-frame search wraps to the
// frames below the search start, and a run may cover all 1024 frames. Claim and free
// write only the words touched; initialise sweeps all 32 words.
// After reset a clearing pass marks every frame free; no request is taken
// meanwhile. The next request is taken while a result waits in the output register;
// a stalled output holds the sequencer once it has its next answer ready.
module bitmap_frame_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // opcode[2:0], frame_index[12:3], page_count[23:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[1:0], frame_result[11:2], zero[15:12]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);
  import bfa_pkg::*;

  logic [CNT_W-1:0] frame_count_r;
  logic [CNT_W-1:0] reserved_count_r;
  logic [FR_W-1:0]  search_start_r;
  logic             out_valid_r;
  result_t          out_res_r;
  logic             eng_idle;
  logic             res_valid;
  result_t          res;
  logic             res_take;
  mem_req_t         mem_req;
  logic [WORD_W-1:0] rdata;
  logic             in_xfer;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r    <= CNT_W'(1024);
      reserved_count_r <= '0;
      search_start_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_COUNT:    frame_count_r    <= cfg_wdata;
        REG_RESERVED_COUNT: reserved_count_r <= cfg_wdata;
        REG_SEARCH_START:   search_start_r   <= cfg_wdata[FR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = eng_idle;
  assign in_xfer   = in_tvalid && in_tready;

  bfa_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (in_xfer),
    .opcode         (in_tdata[2:0]),
    .frame_index    (in_tdata[12:3]),
    .page_count     (in_tdata[23:13]),
    .frame_count    (frame_count_r),
    .reserved_count (reserved_count_r),
    .search_start   (search_start_r),
    .idle           (eng_idle),
    .res_valid      (res_valid),
    .res            (res),
    .res_take       (res_take),
    .mem_req        (mem_req),
    .rdata          (rdata)
  );

  bfa_map_mem u_map (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Output register: loads when empty or when its transfer completes.
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.frame, out_res_r.status};

  // The sequencer never reads and writes the map in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n) !(mem_req.rd_en && mem_req.wr_en))
    else $error("map read and write in the same cycle");

  // Failed requests report frame zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[11:2] == '0)
    else $error("nonzero frame with failing status");

  // An accepted request always occupies the sequencer for the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> !in_tready)
    else $error("sequencer idle right after accepting a request");

endmodule
